FILE: rtl/etrb_pkg.sv
// ----------------------------------------------------------------------------
// etrb_pkg
// shared command codes, request and response types of the event trace ring
// ----------------------------------------------------------------------------
package etrb_pkg;

  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned MAX_W  = 7;

  // command codes on the request channel
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_DRAIN = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // classified operation carried from the front to the back
  typedef enum logic [1:0] {
    OP_ADD,
    OP_DRAIN,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [TIME_W-1:0] uptime_ms;
    logic [7:0]        event_code;
    logic [7:0]        state_code;
    logic [7:0]        detail_code;
    logic [7:0]        flag_bits;
    logic [SEQ_W-1:0]  since_seq;
    logic [MAX_W-1:0]  max_entries;
  } req_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    req_t req;
  } qhead_t;

  typedef struct packed {
    logic              entry_valid;
    logic [SEQ_W-1:0]  entry_seq;
    logic [TIME_W-1:0] entry_uptime;
    logic [7:0]        entry_event;
    logic [7:0]        entry_state;
    logic [7:0]        entry_detail;
    logic [7:0]        entry_flags;
    logic [SEQ_W-1:0]  resume_seq;
    logic [31:0]       drop_count;
    logic [SEQ_W-1:0]  oldest_seq;
    logic              last;
  } rsp_t;

endpackage

FILE: rtl/etrb_if.sv
// ----------------------------------------------------------------------------
// etrb request and response channels
// valid/ready channels carrying the trace ring request and response fields
// ----------------------------------------------------------------------------
interface etrb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] uptime_ms;
  logic [7:0]  event_code;
  logic [7:0]  state_code;
  logic [7:0]  detail_code;
  logic [7:0]  flag_bits;
  logic [31:0] since_seq;
  logic [6:0]  max_entries;

  modport source (
    output valid, cmd, uptime_ms, event_code, state_code, detail_code, flag_bits,
           since_seq, max_entries,
    input  ready
  );
  modport sink (
    input  valid, cmd, uptime_ms, event_code, state_code, detail_code, flag_bits,
           since_seq, max_entries,
    output ready
  );
endinterface

interface etrb_rsp_if;
  logic        valid;
  logic        ready;
  logic        entry_valid;
  logic [31:0] entry_seq;
  logic [31:0] entry_uptime;
  logic [7:0]  entry_event;
  logic [7:0]  entry_state;
  logic [7:0]  entry_detail;
  logic [7:0]  entry_flags;
  logic [31:0] resume_seq;
  logic [31:0] drop_count;
  logic [31:0] oldest_seq;
  logic        last;

  modport source (
    output valid, entry_valid, entry_seq, entry_uptime, entry_event, entry_state,
           entry_detail, entry_flags, resume_seq, drop_count, oldest_seq, last,
    input  ready
  );
  modport sink (
    input  valid, entry_valid, entry_seq, entry_uptime, entry_event, entry_state,
           entry_detail, entry_flags, resume_seq, drop_count, oldest_seq, last,
    output ready
  );
endinterface

FILE: rtl/etrb_front.sv
// ----------------------------------------------------------------------------
// etrb_front
// accepts requests, classifies the command and queues them for the back end
// ----------------------------------------------------------------------------
module etrb_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  etrb_req_if.sink         req_i,
  input  logic             pop_i,
  output etrb_pkg::qhead_t head_o
);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  etrb_pkg::req_t    slot_q [QDEPTH];
  etrb_pkg::req_t    cls;
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pop;

  assign req_i.ready = (cnt_q != QCNT_W'(QDEPTH));
  assign push        = req_i.valid && req_i.ready;
  assign pop         = pop_i && (cnt_q != '0);

  // command decode
  always_comb begin
    cls.uptime_ms   = req_i.uptime_ms;
    cls.event_code  = req_i.event_code;
    cls.state_code  = req_i.state_code;
    cls.detail_code = req_i.detail_code;
    cls.flag_bits   = req_i.flag_bits;
    cls.since_seq   = req_i.since_seq;
    cls.max_entries = req_i.max_entries;
    case (req_i.cmd)
      etrb_pkg::CMD_ADD:   cls.op = etrb_pkg::OP_ADD;
      etrb_pkg::CMD_DRAIN: cls.op = etrb_pkg::OP_DRAIN;
      etrb_pkg::CMD_CLEAR: cls.op = etrb_pkg::OP_CLEAR;
      default:             cls.op = etrb_pkg::OP_NOP;
    endcase
  end

  always_comb begin
    wr_d  = push ? ((wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop  ? ((rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= cls;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.req   = slot_q[rd_q];

endmodule

FILE: rtl/etrb_back.sv
// ----------------------------------------------------------------------------
// etrb_back
// executes add, clear and drain against the ring memory and answers unused commands with a status, one output register
// ----------------------------------------------------------------------------
module etrb_back #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  etrb_pkg::qhead_t head_i,
  output logic             pop_o,
  output etrb_pkg::rsp_t   rsp_o,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // ring memory: {info, time}
  logic [63:0]        mem_q [RING_DEPTH];
  logic [63:0]        rd_data_q;
  logic               wr_en;
  logic               rd_en;
  logic [63:0]        wr_data;

  state_e             state_q, state_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [31:0]        next_seq_q, next_seq_d;
  logic [31:0]        drop_q, drop_d;
  logic [31:0]        since_q, since_d;
  logic [6:0]         max_q, max_d;
  logic [PTR_W-1:0]   slot_q, slot_d;
  logic [31:0]        scan_seq_q, scan_seq_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   emit_q, emit_d;
  logic               hold_valid_q, hold_valid_d;
  logic [31:0]        hold_seq_q, hold_seq_d;
  logic               out_valid_q, out_valid_d;
  etrb_pkg::rsp_t     out_q, out_d;

  logic               out_free;
  logic               push;
  etrb_pkg::rsp_t     push_rsp;
  etrb_pkg::rsp_t     held_rsp;
  logic [31:0]        oldest;
  logic [PTR_W:0]     fs_sum;
  logic [PTR_W-1:0]   first_slot;
  logic [PTR_W-1:0]   slot_inc;
  logic [31:0]        diff;
  logic               qual;
  logic               scan_done;

  assign out_free = !out_valid_q || rsp_ready_i;
  assign oldest   = next_seq_q - 32'(fill_q);
  assign fs_sum   = {1'b0, head_q} + (PTR_W + 1)'(RING_DEPTH) - (PTR_W + 1)'(fill_q);
  assign first_slot = (fs_sum >= (PTR_W + 1)'(RING_DEPTH)) ?
                      PTR_W'(fs_sum - (PTR_W + 1)'(RING_DEPTH)) : PTR_W'(fs_sum);
  assign slot_inc  = (slot_q == PTR_W'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
  assign diff      = scan_seq_q - since_q;
  assign qual      = !diff[31];
  assign scan_done = (idx_q == fill_q) || (32'(emit_q) >= 32'(max_q));
  assign wr_data   = {head_i.req.flag_bits, head_i.req.detail_code,
                      head_i.req.state_code, head_i.req.event_code, head_i.req.uptime_ms};

  // entry taken from the read register, not yet known to be the final one
  always_comb begin
    held_rsp              = '0;
    held_rsp.entry_valid  = 1'b1;
    held_rsp.entry_seq    = hold_seq_q;
    held_rsp.entry_uptime = rd_data_q[31:0];
    held_rsp.entry_event  = rd_data_q[39:32];
    held_rsp.entry_state  = rd_data_q[47:40];
    held_rsp.entry_detail = rd_data_q[55:48];
    held_rsp.entry_flags  = rd_data_q[63:56];
    held_rsp.resume_seq   = next_seq_q;
    held_rsp.drop_count   = drop_q;
    held_rsp.oldest_seq   = oldest;
    held_rsp.last         = 1'b0;
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    fill_d       = fill_q;
    next_seq_d   = next_seq_q;
    drop_d       = drop_q;
    since_d      = since_q;
    max_d        = max_q;
    slot_d       = slot_q;
    scan_seq_d   = scan_seq_q;
    idx_d        = idx_q;
    emit_d       = emit_q;
    hold_valid_d = hold_valid_q;
    hold_seq_d   = hold_seq_q;
    pop_o        = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    push         = 1'b0;
    push_rsp     = '0;
    push_rsp.last = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          case (head_i.req.op)
            etrb_pkg::OP_DRAIN: begin
              pop_o        = 1'b1;
              since_d      = head_i.req.since_seq;
              max_d        = head_i.req.max_entries;
              slot_d       = first_slot;
              scan_seq_d   = oldest;
              idx_d        = '0;
              emit_d       = '0;
              hold_valid_d = 1'b0;
              state_d      = ST_SCAN;
            end
            etrb_pkg::OP_ADD: begin
              if (out_free) begin
                pop_o      = 1'b1;
                wr_en      = 1'b1;
                push       = 1'b1;
                next_seq_d = next_seq_q + 32'd1;
                head_d     = (head_q == PTR_W'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
                if (fill_q != CNT_W'(RING_DEPTH)) begin
                  fill_d = fill_q + 1'b1;
                end else begin
                  drop_d = drop_q + 32'd1;
                end
                push_rsp.resume_seq = next_seq_d;
                push_rsp.drop_count = drop_d;
                push_rsp.oldest_seq = next_seq_d - 32'(fill_d);
              end
            end
            etrb_pkg::OP_CLEAR: begin
              if (out_free) begin
                pop_o      = 1'b1;
                push       = 1'b1;
                head_d     = '0;
                fill_d     = '0;
                next_seq_d = '0;
                drop_d     = '0;
              end
            end
            default: begin
              if (out_free) begin
                pop_o               = 1'b1;
                push                = 1'b1;
                push_rsp.resume_seq = next_seq_q;
                push_rsp.drop_count = drop_q;
                push_rsp.oldest_seq = oldest;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (out_free) begin
            push    = 1'b1;
            state_d = ST_IDLE;
            if (hold_valid_q) begin
              push_rsp            = held_rsp;
              push_rsp.resume_seq = hold_seq_q + 32'd1;
              push_rsp.last       = 1'b1;
            end else begin
              push_rsp.resume_seq = next_seq_q;
              push_rsp.drop_count = drop_q;
              push_rsp.oldest_seq = oldest;
            end
          end
        end else if (qual) begin
          if (!hold_valid_q || out_free) begin
            if (hold_valid_q) begin
              push     = 1'b1;
              push_rsp = held_rsp;
            end
            rd_en        = 1'b1;
            hold_seq_d   = scan_seq_q;
            hold_valid_d = 1'b1;
            emit_d       = emit_q + 1'b1;
            idx_d        = idx_q + 1'b1;
            slot_d       = slot_inc;
            scan_seq_d   = scan_seq_q + 32'd1;
          end
        end else begin
          idx_d      = idx_q + 1'b1;
          slot_d     = slot_inc;
          scan_seq_d = scan_seq_q + 32'd1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = push ? 1'b1 : (rsp_ready_i ? 1'b0 : out_valid_q);
    out_d       = push ? push_rsp : out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      fill_q       <= '0;
      next_seq_q   <= '0;
      drop_q       <= '0;
      since_q      <= '0;
      max_q        <= '0;
      slot_q       <= '0;
      scan_seq_q   <= '0;
      idx_q        <= '0;
      emit_q       <= '0;
      hold_valid_q <= 1'b0;
      hold_seq_q   <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      fill_q       <= fill_d;
      next_seq_q   <= next_seq_d;
      drop_q       <= drop_d;
      since_q      <= since_d;
      max_q        <= max_d;
      slot_q       <= slot_d;
      scan_seq_q   <= scan_seq_d;
      idx_q        <= idx_d;
      emit_q       <= emit_d;
      hold_valid_q <= hold_valid_d;
      hold_seq_q   <= hold_seq_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  // writes only in idle, reads only while scanning
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[head_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[slot_q];
    end
  end

  assign rsp_o       = out_q;
  assign rsp_valid_o = out_valid_q;

endmodule

FILE: rtl/event_trace_ring_buffer_top.sv
// ----------------------------------------------------------------------------
// event_trace_ring_buffer_top
// timestamped event trace ring with overwrite on full, drain and clear
// ----------------------------------------------------------------------------
// add, clear and unused commands: the request is queued, then the back end puts its
// status into the output register; drain walks the held entries oldest first
//   up to max_entries and ends with last set, one memory read port paces the walk
// throughput: one add or clear per cycle from the 2-deep queue while rsp_o is ready
// reset: async active low, ring empty, sequence and drop count zero, no memory clear
module event_trace_ring_buffer_top #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  etrb_req_if.sink    req_i,
  etrb_rsp_if.source  rsp_o
);

  // queue head handed from the front end to the back end
  etrb_pkg::qhead_t head;
  logic             pop;

  // registered response from the back end
  etrb_pkg::rsp_t   rsp;
  logic             rsp_valid;

  // front end: request accept, command decode and command queue
  etrb_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .pop_i  (pop),
    .head_o (head)
  );

  // back end: ring memory, pointers, counters and the drain walker
  etrb_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .rsp_o       (rsp),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready)
  );

  // response channel straight from the output register
  assign rsp_o.valid        = rsp_valid;
  assign rsp_o.entry_valid  = rsp.entry_valid;
  assign rsp_o.entry_seq    = rsp.entry_seq;
  assign rsp_o.entry_uptime = rsp.entry_uptime;
  assign rsp_o.entry_event  = rsp.entry_event;
  assign rsp_o.entry_state  = rsp.entry_state;
  assign rsp_o.entry_detail = rsp.entry_detail;
  assign rsp_o.entry_flags  = rsp.entry_flags;
  assign rsp_o.resume_seq   = rsp.resume_seq;
  assign rsp_o.drop_count   = rsp.drop_count;
  assign rsp_o.oldest_seq   = rsp.oldest_seq;
  assign rsp_o.last         = rsp.last;

endmodule

FILE: rtl/etrb_checker.sv
// ----------------------------------------------------------------------------
// etrb_checker
// port-level checks on the response channel of the trace ring
// ----------------------------------------------------------------------------
module etrb_checker #(
  parameter int unsigned RING_DEPTH = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic        entry_valid_i,
  input logic [31:0] entry_seq_i,
  input logic [31:0] resume_seq_i,
  input logic [31:0] oldest_seq_i,
  input logic        last_i
);

  // a status-only response always closes its request
  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !entry_valid_i |-> last_i)
    else $error("status response without last");

  // the final entry of a drain points one past itself
  a_resume_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && entry_valid_i && last_i |-> resume_seq_i == entry_seq_i + 32'd1)
    else $error("resume sequence mismatch on final entry");

  // an emitted entry lies inside the held window
  a_entry_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && entry_valid_i |-> (entry_seq_i - oldest_seq_i) < 32'(RING_DEPTH))
    else $error("entry outside the held window");

  // stalled response holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(entry_seq_i) && $stable(resume_seq_i))
    else $error("response changed under stall");

endmodule

bind event_trace_ring_buffer_top etrb_checker #(
  .RING_DEPTH (RING_DEPTH)
) u_etrb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (rsp_o.valid),
  .ready_i       (rsp_o.ready),
  .entry_valid_i (rsp_o.entry_valid),
  .entry_seq_i   (rsp_o.entry_seq),
  .resume_seq_i  (rsp_o.resume_seq),
  .oldest_seq_i  (rsp_o.oldest_seq),
  .last_i        (rsp_o.last)
);
